### hdl/pno_pkg.sv
// ----------------------------------------------------------------------------
// pno_pkg: shared types and tables for 2D fractal gradient noise
// Fixed field widths, lattice permutation, gradient selection, cell link type.
// ----------------------------------------------------------------------------
package pno_pkg;

  localparam int IN_W       = 32;
  localparam int FREQ_W     = 24;
  localparam int PROD_W     = IN_W + FREQ_W + 1;
  localparam int OCT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int CELL_W     = 8;
  localparam int OFS_W      = FRAC_W + 1;
  localparam int GRAD_W     = 19;
  localparam int NOISE_W    = 20;
  localparam int FADE_W     = 17;
  localparam int QPOLY_W    = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVE_COUNT = 2'd0,
    CFG_BASE_FREQ    = 2'd1,
    CFG_BASE_AMP     = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    GRAD_XPY = 3'd0,
    GRAD_X   = 3'd1,
    GRAD_XMY = 3'd2,
    GRAD_NY  = 3'd3,
    GRAD_NXY = 3'd4,
    GRAD_NX  = 3'd5,
    GRAD_YMX = 3'd6,
    GRAD_Y   = 3'd7
  } grad_t;

  typedef struct packed {
    logic                     valid;
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
  } pno_link_t;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
    return PERM[idx];
  endfunction

  function automatic logic signed [GRAD_W-1:0] grad_dot(
    input logic [2:0] h,
    input logic signed [OFS_W-1:0] dx,
    input logic signed [OFS_W-1:0] dy
  );
    logic signed [GRAD_W-1:0] ex;
    logic signed [GRAD_W-1:0] ey;
    logic signed [GRAD_W-1:0] res;
    ex = GRAD_W'(dx);
    ey = GRAD_W'(dy);
    case (grad_t'(h))
      GRAD_XPY: res = ex + ey;
      GRAD_X:   res = ex;
      GRAD_XMY: res = ex - ey;
      GRAD_NY:  res = -ey;
      GRAD_NXY: res = -ex - ey;
      GRAD_NX:  res = -ex;
      GRAD_YMX: res = ey - ex;
      GRAD_Y:   res = ey;
      default:  res = ey;
    endcase
    return res;
  endfunction

endpackage

### hdl/perlin_noise_2d_octaves.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d_octaves: fractal 2D gradient noise, one sample per clock when not stalled
// Sums up to MAX_OCTAVES Perlin octaves of a Q16.16 point into Q2.14 noise.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one point (in_x_coord, in_y_coord)
//   per transaction. Output channel out_valid/out_ready returns one
//   out_noise_value per point, in order.
//   Configuration: cfg_we with cfg_index 0 (octave count), 1 (base frequency)
//   or 2 (base amplitude); write only while no transaction is in flight.
// Throughput: one transaction per cycle while the receiver takes results.
// Pipeline: input and product stages, six stages per octave cell, four
//   normalization stages, up to the output register.
// Reset: clears the pipeline and restores octave count 1, base frequency and
//   base amplitude 1.0.
// Stall: a result refused by the receiver moves into a one-entry skid
//   register; the pipeline then holds and in_ready drops until it drains.
// ----------------------------------------------------------------------------
module perlin_noise_2d_octaves #(
  parameter int MAX_OCTAVES     = 8,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pno_pkg::IN_W-1:0]       in_x_coord,
  input  logic signed [pno_pkg::IN_W-1:0]       in_y_coord,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pno_pkg::OUT_W-1:0]      out_noise_value,
  input  logic                                  cfg_we,
  input  logic [pno_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pno_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int ACC_W = 19 + MAX_OCTAVES;
  localparam int CNT_W = $clog2(MAX_OCTAVES + 1);

  logic [pno_pkg::OCT_W-1:0]  octave_count_r;
  logic [pno_pkg::FREQ_W-1:0] base_frequency_r;
  logic [pno_pkg::FREQ_W-1:0] base_amplitude_r;

  logic [CNT_W-1:0] cnt;
  logic             en;
  logic             in_v_r;
  logic signed [pno_pkg::IN_W-1:0] x_r, y_r;
  logic             prod_v_r;
  logic signed [pno_pkg::PROD_W-1:0] px_r, py_r;

  pno_pkg::pno_link_t      link [MAX_OCTAVES+1];
  logic signed [ACC_W-1:0] acc  [MAX_OCTAVES+1];

  logic                              norm_v;
  logic signed [pno_pkg::OUT_W-1:0]  norm_noise;
  logic                              skid_v_r;
  logic signed [pno_pkg::OUT_W-1:0]  skid_noise_r;

  always_comb begin
    if (octave_count_r == '0) begin
      cnt = CNT_W'(1);
    end else if (5'(octave_count_r) > 5'(MAX_OCTAVES)) begin
      cnt = CNT_W'(MAX_OCTAVES);
    end else begin
      cnt = CNT_W'(octave_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r   <= pno_pkg::OCT_W'(1);
      base_frequency_r <= pno_pkg::FREQ_W'(65536);
      base_amplitude_r <= pno_pkg::FREQ_W'(65536);
    end else if (cfg_we) begin
      case (pno_pkg::cfg_idx_t'(cfg_index))
        pno_pkg::CFG_OCTAVE_COUNT: octave_count_r   <= cfg_wdata[pno_pkg::OCT_W-1:0];
        pno_pkg::CFG_BASE_FREQ:    base_frequency_r <= cfg_wdata;
        pno_pkg::CFG_BASE_AMP:     base_amplitude_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !skid_v_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else if (en) begin
      in_v_r   <= in_valid;
      prod_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= in_x_coord;
      y_r  <= in_y_coord;
      px_r <= x_r * $signed({1'b0, base_frequency_r});
      py_r <= y_r * $signed({1'b0, base_frequency_r});
    end
  end

  assign link[0].valid = prod_v_r;
  assign link[0].px    = px_r;
  assign link[0].py    = py_r;
  assign acc[0]        = '0;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    pno_octave #(
      .OCT_IDX (k),
      .CFB     (COORD_FRAC_BITS),
      .ACC_W   (ACC_W),
      .CNT_W   (CNT_W)
    ) u_oct (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .cnt    (cnt),
      .link_i (link[k]),
      .acc_i  (acc[k]),
      .link_o (link[k+1]),
      .acc_o  (acc[k+1])
    );
  end

  pno_norm #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .ACC_W       (ACC_W),
    .CNT_W       (CNT_W)
  ) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_i  (link[MAX_OCTAVES].valid),
    .acc_i    (acc[MAX_OCTAVES]),
    .cnt      (cnt),
    .amp_zero (base_amplitude_r == '0),
    .valid_o  (norm_v),
    .noise_o  (norm_noise)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      skid_v_r <= !out_ready;
    end else begin
      skid_v_r <= norm_v && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_noise_r <= norm_noise;
    end
  end

  assign out_valid       = skid_v_r || norm_v;
  assign out_noise_value = skid_v_r ? skid_noise_r : norm_noise;

`ifndef SYNTH
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("refused transaction changed or dropped");

  a_skid_load_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(norm_v && !out_ready))
    else $error("skid loaded without a refused transaction");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ready |=> skid_v_r && $stable(skid_noise_r))
    else $error("skid lost a pending transaction");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

### hdl/pno_octave.sv
// ----------------------------------------------------------------------------
// pno_octave: one octave cell of the noise chain
// Six stages: lattice split and hashing, quintic fade, gradients, bilinear
// blend, then adds its weighted sample to the running sum from its neighbor.
// ----------------------------------------------------------------------------
module pno_octave #(
  parameter int OCT_IDX = 0,
  parameter int CFB     = 16,
  parameter int ACC_W   = 27,
  parameter int CNT_W   = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic [CNT_W-1:0]        cnt,
  input  pno_pkg::pno_link_t      link_i,
  input  logic signed [ACC_W-1:0] acc_i,
  output pno_pkg::pno_link_t      link_o,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam int NST = 6;

  function automatic logic [pno_pkg::QPOLY_W-1:0] q_poly(
    input logic [2*pno_pkg::FRAC_W-1:0] f2,
    input logic [pno_pkg::FRAC_W-1:0]   f
  );
    logic signed [39:0] s;
    s = $signed({8'd0, f2}) * 40'sd6 - (($signed({24'd0, f}) * 40'sd15) <<< 16)
        + (40'sd10 <<< 32);
    return s[16 +: pno_pkg::QPOLY_W];
  endfunction

  function automatic logic signed [pno_pkg::NOISE_W-1:0] lerp(
    input logic signed [pno_pkg::NOISE_W-1:0] a,
    input logic signed [pno_pkg::NOISE_W-1:0] b,
    input logic [pno_pkg::FADE_W-1:0]         t
  );
    logic signed [pno_pkg::NOISE_W:0]                   d;
    logic signed [pno_pkg::NOISE_W+pno_pkg::FADE_W+1:0] p;
    logic signed [pno_pkg::NOISE_W+pno_pkg::FADE_W+1:0] s;
    d = (pno_pkg::NOISE_W+1)'(b) - (pno_pkg::NOISE_W+1)'(a);
    p = d * $signed({1'b0, t});
    s = (p >>> 16) + (pno_pkg::NOISE_W+pno_pkg::FADE_W+2)'(a);
    return s[pno_pkg::NOISE_W-1:0];
  endfunction

  logic                            v_r   [NST];
  logic signed [pno_pkg::PROD_W-1:0] px_r [NST];
  logic signed [pno_pkg::PROD_W-1:0] py_r [NST];
  logic signed [ACC_W-1:0]         acc_r [NST];

  // stage 1
  logic [63:0] ux, uy;
  logic [7:0]  xi, yi;
  logic [pno_pkg::FRAC_W-1:0] fx, fy;
  logic [7:0]  yi1_r, px0_r, px1_r;
  logic [pno_pkg::FRAC_W-1:0] fx1_r, fy1_r;
  logic [2*pno_pkg::FRAC_W-1:0] fx2_r, fy2_r;

  // stage 2
  logic [2:0]  h00_r, h01_r, h10_r, h11_r;
  logic [pno_pkg::FRAC_W-1:0] fx2s_r, fy2s_r;
  logic [3*pno_pkg::FRAC_W-1:0] cx, cy;
  logic [pno_pkg::FRAC_W-1:0] t3x_r, t3y_r;
  logic [pno_pkg::QPOLY_W-1:0] qx_r, qy_r;

  // stage 3
  logic [pno_pkg::FRAC_W+pno_pkg::QPOLY_W-1:0] mu, mv;
  logic [pno_pkg::FADE_W-1:0] u3_r, v3_r;
  logic signed [pno_pkg::OFS_W-1:0] x0, x1, y0, y1;
  logic signed [pno_pkg::GRAD_W-1:0] g00_r, g01_r, g10_r, g11_r;

  // stage 4, 5
  logic signed [pno_pkg::NOISE_W-1:0] r0_r, r1_r, n_r;
  logic [pno_pkg::FADE_W-1:0] v4_r;

  // stage 6
  logic                    active;
  logic [CNT_W-1:0]        sh;
  logic signed [ACC_W-1:0] wt;

  assign ux = 64'(link_i.px) << OCT_IDX;
  assign uy = 64'(link_i.py) << OCT_IDX;
  assign xi = ux[CFB+16 +: 8];
  assign yi = uy[CFB+16 +: 8];
  assign fx = ux[CFB +: pno_pkg::FRAC_W];
  assign fy = uy[CFB +: pno_pkg::FRAC_W];

  assign cx = fx2_r * fx1_r;
  assign cy = fy2_r * fy1_r;

  assign mu = t3x_r * qx_r;
  assign mv = t3y_r * qy_r;
  assign x0 = $signed({1'b0, fx2s_r});
  assign x1 = $signed({1'b1, fx2s_r});
  assign y0 = $signed({1'b0, fy2s_r});
  assign y1 = $signed({1'b1, fy2s_r});

  assign active = cnt > CNT_W'(OCT_IDX);
  assign sh     = cnt - CNT_W'(OCT_IDX + 1);
  assign wt     = active ? (ACC_W'(n_r) <<< sh) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= link_i.valid;
      for (int i = 1; i < NST; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0]  <= link_i.px;
      py_r[0]  <= link_i.py;
      acc_r[0] <= acc_i;
      for (int i = 1; i < NST; i++) begin
        px_r[i] <= px_r[i-1];
        py_r[i] <= py_r[i-1];
      end
      for (int i = 1; i < NST - 1; i++) acc_r[i] <= acc_r[i-1];
      acc_r[NST-1] <= acc_r[NST-2] + wt;

      yi1_r <= yi;
      px0_r <= pno_pkg::perm_lookup(xi);
      px1_r <= pno_pkg::perm_lookup(xi + 8'd1);
      fx1_r <= fx;
      fy1_r <= fy;
      fx2_r <= fx * fx;
      fy2_r <= fy * fy;

      h00_r  <= 3'(pno_pkg::perm_lookup(px0_r + yi1_r));
      h01_r  <= 3'(pno_pkg::perm_lookup(px0_r + yi1_r + 8'd1));
      h10_r  <= 3'(pno_pkg::perm_lookup(px1_r + yi1_r));
      h11_r  <= 3'(pno_pkg::perm_lookup(px1_r + yi1_r + 8'd1));
      fx2s_r <= fx1_r;
      fy2s_r <= fy1_r;
      t3x_r  <= cx[3*pno_pkg::FRAC_W-1 -: pno_pkg::FRAC_W];
      t3y_r  <= cy[3*pno_pkg::FRAC_W-1 -: pno_pkg::FRAC_W];
      qx_r   <= q_poly(fx2_r, fx1_r);
      qy_r   <= q_poly(fy2_r, fy1_r);

      u3_r  <= mu[16 +: pno_pkg::FADE_W];
      v3_r  <= mv[16 +: pno_pkg::FADE_W];
      g00_r <= pno_pkg::grad_dot(h00_r, x0, y0);
      g10_r <= pno_pkg::grad_dot(h10_r, x1, y0);
      g01_r <= pno_pkg::grad_dot(h01_r, x0, y1);
      g11_r <= pno_pkg::grad_dot(h11_r, x1, y1);

      r0_r <= lerp(pno_pkg::NOISE_W'(g00_r), pno_pkg::NOISE_W'(g10_r), u3_r);
      r1_r <= lerp(pno_pkg::NOISE_W'(g01_r), pno_pkg::NOISE_W'(g11_r), u3_r);
      v4_r <= v3_r;

      n_r <= lerp(r0_r, r1_r, v4_r);
    end
  end

  assign link_o.valid = v_r[NST-1];
  assign link_o.px    = px_r[NST-1];
  assign link_o.py    = py_r[NST-1];
  assign acc_o        = acc_r[NST-1];

endmodule

### hdl/pno_norm.sv
// ----------------------------------------------------------------------------
// pno_norm: normalization of the octave sum
// Divides by 4*(2^K-1) with a reciprocal multiply and one correction step,
// truncates toward zero, saturates to the output width and gives zero when amp_zero is set.
// ----------------------------------------------------------------------------
module pno_norm #(
  parameter int MAX_OCTAVES = 8,
  parameter int ACC_W       = 27,
  parameter int CNT_W       = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                valid_i,
  input  logic signed [ACC_W-1:0]             acc_i,
  input  logic [CNT_W-1:0]                    cnt,
  input  logic                                amp_zero,
  output logic                                valid_o,
  output logic signed [pno_pkg::OUT_W-1:0]    noise_o
);

  localparam int A_W   = ACC_W - 2;
  localparam int R_W   = ACC_W + 1;
  localparam int QD_W  = A_W + MAX_OCTAVES;
  localparam int NST   = 4;
  localparam logic [A_W-1:0] POS_MAX = A_W'((1 << (pno_pkg::OUT_W - 1)) - 1);
  localparam logic [A_W-1:0] NEG_MAX = A_W'(1 << (pno_pkg::OUT_W - 1));

  logic [R_W-1:0] recip [MAX_OCTAVES+1];

  assign recip[0] = '0;
  for (genvar g = 1; g <= MAX_OCTAVES; g++) begin : g_recip
    localparam longint unsigned RV = (64'd1 << ACC_W) / ((64'd1 << g) - 64'd1);
    assign recip[g] = R_W'(RV);
  end

  logic               v_r [NST];
  logic [ACC_W-1:0]   mag;
  logic               neg1_r, neg2_r, neg3_r;
  logic [A_W-1:0]     a1_r, a2_r;
  logic [A_W+R_W-1:0] prod;
  logic [A_W-1:0]     qe_r;
  logic [QD_W-1:0]    qd;
  logic [MAX_OCTAVES-1:0] dv;
  logic [A_W-1:0]     rem;
  logic [A_W-1:0]     q_r;
  logic signed [pno_pkg::OUT_W-1:0] res;

  assign mag  = acc_i[ACC_W-1] ? ACC_W'(-acc_i) : ACC_W'(acc_i);
  assign prod = a1_r * recip[cnt];
  assign qd   = (QD_W'(qe_r) << cnt) - QD_W'(qe_r);
  assign dv   = MAX_OCTAVES'((QD_W'(1) << cnt) - QD_W'(1));
  assign rem  = a2_r - qd[A_W-1:0];

  always_comb begin
    if (amp_zero) begin
      res = '0;
    end else if (!neg3_r) begin
      res = (q_r > POS_MAX) ? pno_pkg::OUT_W'(POS_MAX) : pno_pkg::OUT_W'(q_r);
    end else begin
      res = (q_r > NEG_MAX) ? -pno_pkg::OUT_W'(NEG_MAX) : -pno_pkg::OUT_W'(q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= valid_i;
      for (int i = 1; i < NST; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= acc_i[ACC_W-1];
      a1_r    <= mag[ACC_W-1:2];
      neg2_r  <= neg1_r;
      a2_r    <= a1_r;
      qe_r    <= prod[ACC_W +: A_W];
      neg3_r  <= neg2_r;
      q_r     <= (rem >= A_W'(dv)) ? qe_r + A_W'(1) : qe_r;
      noise_o <= res;
    end
  end

  assign valid_o = v_r[NST-1];

endmodule
